/* src/occ_pkg.sv */
// Shared types, constants and the divider step function for the occupancy checker.
package occ_pkg;

  // Divider geometry: 26-bit unsigned words, two quotient bits per stage
  localparam int DIV_W      = 26;
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = DIV_W / DIV_BPS;
  localparam int REM_W      = DIV_W + 1;

  // Configuration register indexes
  localparam logic [2:0] REG_WARP_SIZE   = 3'd0;
  localparam logic [2:0] REG_MAX_WARPS   = 3'd1;
  localparam logic [2:0] REG_GRANULE     = 3'd2;
  localparam logic [2:0] REG_SHARED_SIZE = 3'd3;
  localparam logic [2:0] REG_CORE_COUNT  = 3'd4;

  // Granule used when the granule register holds zero
  localparam logic [12:0] DEFAULT_GRANULE = 13'd64;

  typedef logic [DIV_W-1:0] div_word_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    div_word_t        dq;   // dividend shifting out, quotient shifting in
    div_word_t        dvs;
  } div_stage_t;

  // Two restoring-division steps
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t       t;
    logic [REM_W-1:0] r;
    t = s;
    for (int k = 0; k < DIV_BPS; k++) begin
      r    = {t.rem[REM_W-2:0], t.dq[DIV_W-1]};
      t.dq = {t.dq[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, t.dvs}) begin
        r       = r - {1'b0, t.dvs};
        t.dq[0] = 1'b1;
      end
      t.rem = r;
    end
    return t;
  endfunction

endpackage

/* src/cta_occupancy_and_cooperative_check_top.sv */
// Launch occupancy and cooperative-fit checker, top level.
// Path: capture, first divider pair, mid stage, second pair, m1, m2, output register.
// Throughput: one request per cycle; busy is never raised, set by the two chained
// pipelined dividers (warp count then warp-slot bound, stride then memory bound).
// Reset (synchronous, rst_n low) empties the pipeline and restores register defaults.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module cta_occupancy_and_cooperative_check_top (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_block_threads,
  input  logic [23:0] in_smem_bytes,
  input  logic [15:0] in_grid_x,
  input  logic [15:0] in_grid_y,
  input  logic [15:0] in_grid_z,
  // result channel
  output logic        out_valid,
  output logic [10:0] out_blocks_per_core,
  output logic        out_coop_status,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import occ_pkg::*;

  localparam int PIPE_LAT = 2 * DIV_STAGES + 5;

  typedef struct packed {
    logic      zero_n;
    logic      smem_zero;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] gz;
    div_word_t bdiv;
  } side_t;

  // configuration registers
  logic [6:0]  warp_size_r;
  logic [10:0] max_warps_r;
  logic [12:0] granule_r;
  logic [24:0] shared_size_r;
  logic [10:0] core_count_r;
  logic [2:0]  reg_idx;
  logic [12:0] gran_eff;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[4:2];
  assign gran_eff = (granule_r == '0) ? DEFAULT_GRANULE : granule_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warp_size_r   <= 7'd32;
      max_warps_r   <= 11'd32;
      granule_r     <= 13'd64;
      shared_size_r <= 25'd16384;
      core_count_r  <= 11'd4;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_WARP_SIZE:   warp_size_r   <= pwdata[6:0];
        REG_MAX_WARPS:   max_warps_r   <= pwdata[10:0];
        REG_GRANULE:     granule_r     <= pwdata[12:0];
        REG_SHARED_SIZE: shared_size_r <= pwdata[24:0];
        REG_CORE_COUNT:  core_count_r  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WARP_SIZE:   prdata = {25'd0, warp_size_r};
      REG_MAX_WARPS:   prdata = {21'd0, max_warps_r};
      REG_GRANULE:     prdata = {19'd0, granule_r};
      REG_SHARED_SIZE: prdata = {7'd0, shared_size_r};
      REG_CORE_COUNT:  prdata = {21'd0, core_count_r};
      default:         prdata = '0;
    endcase
  end

  // stage 1: capture request
  logic        s1_vld_r;
  logic [15:0] s1_thr_r, s1_gx_r, s1_gy_r, s1_gz_r;
  logic [23:0] s1_smem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_thr_r  <= in_block_threads;
    s1_smem_r <= in_smem_bytes;
    s1_gx_r   <= (in_grid_x == '0) ? 16'd1 : in_grid_x;
    s1_gy_r   <= (in_grid_y == '0) ? 16'd1 : in_grid_y;
    s1_gz_r   <= (in_grid_z == '0) ? 16'd1 : in_grid_z;
  end

  // first divider pair: warp count and granule remainder
  side_t     s1_side;
  div_word_t da_dvd, da_dvs, db_dvd, db_dvs;
  logic      da_vld, db_vld;
  div_word_t qa, ra, qb, rb;

  assign s1_side.zero_n    = (s1_thr_r == '0) || (warp_size_r == '0);
  assign s1_side.smem_zero = (s1_smem_r == '0);
  assign s1_side.gx        = s1_gx_r;
  assign s1_side.gy        = s1_gy_r;
  assign s1_side.gz        = s1_gz_r;
  assign s1_side.bdiv      = db_dvd;

  assign da_dvd = DIV_W'({10'd0, s1_thr_r} + {19'd0, warp_size_r} - 26'd1);
  assign da_dvs = (warp_size_r == '0) ? DIV_W'(1) : {19'd0, warp_size_r};
  assign db_dvd = DIV_W'({2'd0, s1_smem_r} + {13'd0, gran_eff} - 26'd1);
  assign db_dvs = {13'd0, gran_eff};

  occ_div u_div_a (
    .clk(clk), .rst_n(rst_n), .in_vld(s1_vld_r), .in_dividend(da_dvd),
    .in_divisor(da_dvs), .out_vld(da_vld), .out_quot(qa), .out_rem(ra));

  occ_div u_div_b (
    .clk(clk), .rst_n(rst_n), .in_vld(s1_vld_r), .in_dividend(db_dvd),
    .in_divisor(db_dvs), .out_vld(db_vld), .out_quot(qb), .out_rem(rb));

  // side data riding alongside the first dividers
  side_t sha_r [DIV_STAGES];
  always_ff @(posedge clk) begin
    sha_r[0] <= s1_side;
    for (int i = 1; i < DIV_STAGES; i++) sha_r[i] <= sha_r[i-1];
  end

  // mid stage: warps and stride
  logic      mid_vld_r;
  side_t     mid_side_r;
  div_word_t mid_warps_r, mid_stride_r;
  div_word_t stride;

  assign stride = sha_r[DIV_STAGES-1].bdiv - rb;

  always_ff @(posedge clk) begin
    if (!rst_n) mid_vld_r <= 1'b0;
    else        mid_vld_r <= da_vld && db_vld;
  end

  always_ff @(posedge clk) begin
    mid_side_r   <= sha_r[DIV_STAGES-1];
    mid_warps_r  <= (qa == '0) ? DIV_W'(1) : qa;
    mid_stride_r <= (stride == '0) ? DIV_W'(1) : stride;
  end

  // second divider pair: warp-slot bound and shared-memory bound
  div_word_t dc_dvd, dd_dvd;
  logic      dc_vld, dd_vld;
  div_word_t qc, rc, qd, rd;

  assign dc_dvd = {15'd0, max_warps_r};
  assign dd_dvd = {1'b0, shared_size_r};

  occ_div u_div_c (
    .clk(clk), .rst_n(rst_n), .in_vld(mid_vld_r), .in_dividend(dc_dvd),
    .in_divisor(mid_warps_r), .out_vld(dc_vld), .out_quot(qc), .out_rem(rc));

  occ_div u_div_d (
    .clk(clk), .rst_n(rst_n), .in_vld(mid_vld_r), .in_dividend(dd_dvd),
    .in_divisor(mid_stride_r), .out_vld(dd_vld), .out_quot(qd), .out_rem(rd));

  side_t shb_r [DIV_STAGES];
  always_ff @(posedge clk) begin
    shb_r[0] <= mid_side_r;
    for (int i = 1; i < DIV_STAGES; i++) shb_r[i] <= shb_r[i-1];
  end

  // m1: minimum of bounds, first grid product
  side_t       sb;
  logic [10:0] mem_lim, n_nxt;
  logic        m1_vld_r;
  logic [10:0] m1_n_r;
  logic [31:0] m1_gxy_r;
  logic [15:0] m1_gz_r;

  assign sb = shb_r[DIV_STAGES-1];

  always_comb begin
    if (sb.smem_zero || (qd >= {15'd0, max_warps_r})) mem_lim = max_warps_r;
    else                                              mem_lim = qd[10:0];
    // warp-slot bound never exceeds the slot count
    n_nxt = (qc[10:0] < mem_lim) ? qc[10:0] : mem_lim;
    if (sb.zero_n) n_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m1_vld_r <= 1'b0;
    else        m1_vld_r <= dc_vld && dd_vld;
  end

  always_ff @(posedge clk) begin
    m1_n_r   <= n_nxt;
    m1_gxy_r <= {16'd0, sb.gx} * {16'd0, sb.gy};
    m1_gz_r  <= sb.gz;
  end

  // m2: grid volume and capacity
  logic        m2_vld_r;
  logic [10:0] m2_n_r;
  logic [47:0] m2_vol_r;
  logic [21:0] m2_cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m2_vld_r <= 1'b0;
    else        m2_vld_r <= m1_vld_r;
  end

  always_ff @(posedge clk) begin
    m2_n_r   <= m1_n_r;
    m2_vol_r <= {16'd0, m1_gxy_r} * {32'd0, m1_gz_r};
    m2_cap_r <= {11'd0, m1_n_r} * {11'd0, core_count_r};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= m2_vld_r;
  end

  always_ff @(posedge clk) begin
    out_blocks_per_core <= m2_n_r;
    out_coop_status     <= (m2_n_r == '0) || (m2_vol_r > {26'd0, m2_cap_r})
                           || (m2_vol_r < {37'd0, core_count_r});
  end

  // checks
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("request result missing at expected latency");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_blocks_per_core <= max_warps_r))
    else $error("occupancy above slot count");

  a_zero_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_blocks_per_core == '0)) |-> out_coop_status)
    else $error("zero occupancy reported as cooperative fit");

  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    (da_vld == db_vld) && (dc_vld == dd_vld))
    else $error("divider pipelines out of step");

endmodule

/* src/occ_div.sv */
// Pipelined unsigned divider, two quotient bits per stage.
module occ_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  occ_pkg::div_word_t in_dividend,
  input  occ_pkg::div_word_t in_divisor,
  output logic              out_vld,
  output occ_pkg::div_word_t out_quot,
  output occ_pkg::div_word_t out_rem
);
  import occ_pkg::*;

  div_stage_t stage_r [DIV_STAGES];
  logic       vld_r   [DIV_STAGES];
  div_stage_t init;

  assign init = '{rem: '0, dq: in_dividend, dvs: in_divisor};

  // datapath stages
  always_ff @(posedge clk) begin
    stage_r[0] <= div_step(init);
    for (int i = 1; i < DIV_STAGES; i++) begin
      stage_r[i] <= div_step(stage_r[i-1]);
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < DIV_STAGES; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_quot = stage_r[DIV_STAGES-1].dq;
  assign out_rem  = stage_r[DIV_STAGES-1].rem[DIV_W-1:0];

endmodule

/* bench/testbench.sv */
// Self-checking bench for the launch occupancy and cooperative-fit checker.
`timescale 1ns / 1ps

module testbench;
  import occ_pkg::*;

  // Pipeline depth of the block
  localparam int PIPE_LAT    = 2 * DIV_STAGES + 5;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [10:0] blocks_per_core;
    logic        coop_status;
  } occ_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_block_threads = '0;
  logic [23:0] in_smem_bytes = '0;
  logic [15:0] in_grid_x = '0;
  logic [15:0] in_grid_y = '0;
  logic [15:0] in_grid_z = '0;
  logic        out_valid;
  logic [10:0] out_blocks_per_core;
  logic        out_coop_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the configuration registers
  longint unsigned cfg_warp, cfg_slots, cfg_granule, cfg_shared, cfg_cores;

  occ_result_t occ_expect_q[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_coop_ok = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;

  cta_occupancy_and_cooperative_check_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_block_threads(in_block_threads), .in_smem_bytes(in_smem_bytes),
    .in_grid_x(in_grid_x), .in_grid_y(in_grid_y), .in_grid_z(in_grid_z),
    .out_valid(out_valid), .out_blocks_per_core(out_blocks_per_core),
    .out_coop_status(out_coop_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Resident blocks per core: min of warp-slot bound, slot count and shared-memory bound
  function automatic longint unsigned resident_blocks(logic [15:0] thr, logic [23:0] smem);
    longint unsigned warps, n, mem_bound, g, stride;
    if (thr == 0 || cfg_warp == 0) return 0;
    warps = (thr + cfg_warp - 1) / cfg_warp;
    n = cfg_slots / warps;
    if (cfg_slots < n) n = cfg_slots;
    mem_bound = cfg_slots;
    if (smem != 0) begin
      g = (cfg_granule != 0) ? cfg_granule : 64;
      stride = ((smem + g - 1) / g) * g;
      mem_bound = cfg_shared / stride;
    end
    if (mem_bound < n) n = mem_bound;
    return n;
  endfunction

  function automatic occ_result_t predict_launch(logic [15:0] thr, logic [23:0] smem,
                                                 logic [15:0] gx, logic [15:0] gy,
                                                 logic [15:0] gz);
    occ_result_t     r;
    longint unsigned n, vol;
    n   = resident_blocks(thr, smem);
    vol = longint'(gx == 0 ? 1 : gx) * longint'(gy == 0 ? 1 : gy) *
          longint'(gz == 0 ? 1 : gz);
    r.blocks_per_core = n[10:0];
    r.coop_status = (n == 0) || (vol > n * cfg_cores) || (vol < cfg_cores);
    return r;
  endfunction

  // Result checker: the receiver never stalls
  always @(posedge clk) begin
    occ_result_t e;
    if (rst_n && out_valid) begin
      if (occ_expect_q.size() == 0) begin
        $error("result with no pending request: blocks_per_core=%0d coop_status=%0d",
               out_blocks_per_core, out_coop_status);
        errors++;
      end else begin
        e = occ_expect_q.pop_front();
        n_checked++;
        if (out_blocks_per_core !== e.blocks_per_core) begin
          $error("blocks_per_core expected %0d got %0d", e.blocks_per_core,
                 out_blocks_per_core);
          errors++;
        end
        if (out_coop_status !== e.coop_status) begin
          $error("coop_status expected %0d got %0d", e.coop_status, out_coop_status);
          errors++;
        end
      end
    end
  end

  // Called just after a rising edge; leaves start high for a following request
  task automatic send_request(logic [15:0] thr, logic [23:0] smem,
                              logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_block_threads <= thr;
    in_smem_bytes <= smem;
    in_grid_x <= gx;
    in_grid_y <= gy;
    in_grid_z <= gz;
    @(posedge clk);
    while (busy) @(posedge clk);
    occ_expect_q.insert(occ_expect_q.size(), predict_launch(thr, smem, gx, gy, gz));
    if (!predict_launch(thr, smem, gx, gy, gz).coop_status) n_coop_ok++;
    n_sent++;
  endtask

  // Stop sending and wait for all pending results, then let the pipe settle
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (occ_expect_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WARP_SIZE:   cfg_warp    = val & 32'h7F;
      REG_MAX_WARPS:   cfg_slots   = val & 32'h7FF;
      REG_GRANULE:     cfg_granule = val & 32'h1FFF;
      REG_SHARED_SIZE: cfg_shared  = val & 32'h1FFFFFF;
      REG_CORE_COUNT:  cfg_cores   = val & 32'h7FF;
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned w, int unsigned s, int unsigned g,
                           int unsigned m, int unsigned c);
    write_reg(REG_WARP_SIZE, w);
    write_reg(REG_MAX_WARPS, s);
    write_reg(REG_GRANULE, g);
    write_reg(REG_SHARED_SIZE, m);
    write_reg(REG_CORE_COUNT, c);
  endtask

  // One random request; mostly aimed near the cooperative-fit boundaries
  task automatic random_request();
    logic [15:0]     thr, gx, gy, gz;
    logic [23:0]     smem;
    longint unsigned n, lo, hi, t;
    case ($urandom_range(3))
      0: thr = 16'($urandom);
      default: thr = 16'($urandom_range(0, 1100));
    endcase
    case ($urandom_range(4))
      0: smem = 24'($urandom);
      1: smem = 24'd0;
      default: smem = 24'($urandom_range(0, 20000));
    endcase
    gx = 16'($urandom);
    gy = 16'($urandom);
    gz = 16'($urandom);
    n = resident_blocks(thr, smem);
    if ($urandom_range(99) < 70) begin
      lo = cfg_cores;
      hi = n * cfg_cores;
      if (hi < lo) hi = lo;
      case ($urandom_range(5))
        0: t = lo;
        1: t = hi;
        2: t = hi + 1;
        3: t = (lo > 0) ? lo - 1 : 0;
        default: t = lo + ($urandom % (hi - lo + 1));
      endcase
      gy = 16'((t + 65534) / 65535);
      gx = 16'((gy != 0) ? t / gy : 0);
      gz = 16'($urandom_range(0, 1));
    end
    send_request(thr, smem, gx, gy, gz);
  endtask

  task automatic random_config();
    int unsigned w, s, g, m, c;
    w = $urandom_range(2) == 0 ? 32 : $urandom_range(0, 64);
    s = $urandom_range(3) == 0 ? $urandom_range(0, 1024) : $urandom_range(1, 64);
    g = $urandom_range(2) == 0 ? 64 : $urandom_range(0, 4096);
    m = $urandom_range(2) == 0 ? $urandom_range(0, 16777216) : $urandom_range(0, 65536);
    c = $urandom_range(3) == 0 ? $urandom_range(0, 1024) : $urandom_range(1, 16);
    write_all(w, s, g, m, c);
  endtask

  // Edges of the fields and named corner cases, under reset defaults and other settings
  task automatic test_directed();
    send_request(16'd0, 24'd0, 16'd4, 16'd1, 16'd1);
    send_request(16'd32, 24'd0, 16'd4, 16'd1, 16'd1);
    send_request(16'd33, 24'd64, 16'd0, 16'd0, 16'd0);
    send_request(16'd1, 24'd1, 16'd128, 16'd1, 16'd1);
    send_request(16'd1, 24'd1, 16'd129, 16'd1, 16'd1);
    send_request(16'd1, 24'd1, 16'd3, 16'd1, 16'd1);
    send_request(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(16'd1024, 24'd16384, 16'd4, 16'd0, 16'd1);
    send_request(16'd64, 24'd16385, 16'd4, 16'd1, 16'd1);
    send_request(16'd1, 24'd512, 16'd2, 16'd2, 16'd2);
    wait_drained();
    // zero warp size, zero granule, zero cores
    write_all(0, 32, 0, 16384, 0);
    send_request(16'd32, 24'd100, 16'd1, 16'd1, 16'd1);
    wait_drained();
    write_reg(REG_WARP_SIZE, 32);
    send_request(16'd32, 24'd65, 16'd1, 16'd1, 16'd1);
    send_request(16'd32, 24'd0, 16'd0, 16'd0, 16'd0);
    wait_drained();
    // upper extremes of the random configuration ranges for every register
    write_all(64, 1024, 4096, 16777216, 1024);
    send_request(16'd1, 24'd1, 16'd1024, 16'd1024, 16'd1);
    send_request(16'd1, 24'd1, 16'd1024, 16'd1023, 16'd1);
    send_request(16'd64, 24'd4096, 16'd1024, 16'd1, 16'd1);
    send_request(16'hFFFF, 24'd0, 16'd1024, 16'd1, 16'd1);
    wait_drained();
    // low settings: warp size, granule and cores at one, slots and shared size at zero
    write_all(1, 0, 1, 0, 1);
    send_request(16'd1, 24'd0, 16'd1, 16'd1, 16'd1);
    send_request(16'd1, 24'd1, 16'd1, 16'd1, 16'd1);
    wait_drained();
  endtask

  task automatic test_random_phase(int unsigned pct, int unsigned count);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 99) begin
        wait_drained();
        random_config();
      end
      random_request();
      // sender holds off once until everything is back
      if (i == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    cfg_warp = 32;
    cfg_slots = 32;
    cfg_granule = 64;
    cfg_shared = 16384;
    cfg_cores = 4;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_all(32, 32, 64, 16384, 4);
    test_random_phase(26, 430);
    test_random_phase(58, 430);
    test_random_phase(0, 440);
    if (occ_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", occ_expect_q.size());
      errors++;
    end
    $display("Sent %0d launch queries over many register settings, %0d results checked,",
             n_sent, n_checked);
    $display("%0d of them cooperative fits; %0d mismatches", n_coop_ok, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/occ_pkg.sv
src/occ_div.sv
src/cta_occupancy_and_cooperative_check_top.sv
bench/testbench.sv
